/* rtl/smp_pkg.sv */
// Shared types and constants for the framed message parser.
// No dependencies; imported by smp_payload_ram and sync_framed_message_parser.
package smp_pkg;

  localparam int unsigned MaxPayload = 255;
  localparam int unsigned AddrW      = 8;

  localparam logic [15:0]      MaxPayloadLen = 16'(MaxPayload);
  localparam logic [AddrW-1:0] MaxPayloadIdx = AddrW'(MaxPayload);
  localparam logic [7:0]       PosSat        = 8'hFF;

  localparam logic [7:0] SyncFirstRst  = 8'hB5;
  localparam logic [7:0] SyncSecondRst = 8'h62;
  localparam logic [7:0] MaxLengthRst  = 8'd255;

  typedef enum logic [1:0] {
    OpRxByte  = 2'd0,
    OpRead    = 2'd1,
    OpRelease = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CfgSyncFirst  = 2'd0,
    CfgSyncSecond = 2'd1,
    CfgMaxLength  = 2'd2
  } cfg_e;

  typedef enum logic [8:0] {
    PhHunt    = 9'b000000001,
    PhSync1   = 9'b000000010,
    PhClass   = 9'b000000100,
    PhIdent   = 9'b000001000,
    PhLenLo   = 9'b000010000,
    PhLenHi   = 9'b000100000,
    PhPayload = 9'b001000000,
    PhCkA     = 9'b010000000,
    PhCkB     = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } smp_in_t;

  typedef struct packed {
    logic       frame_ready;
    logic       frame_done;
    logic       frame_error;
    logic [7:0] frame_class;
    logic [7:0] msg_ident;
    logic [7:0] payload_length;
    logic [7:0] read_data;
    logic [7:0] error_count;
  } smp_out_t;

endpackage

/* rtl/smp_payload_ram.sv */
// Payload store: one write port, one registered read port with
// write-to-read forwarding. Depends on smp_pkg.
module smp_payload_ram (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [smp_pkg::AddrW-1:0] wr_addr_i,
  input  logic [7:0]              wr_data_i,
  input  logic                    rd_en_i,
  input  logic [smp_pkg::AddrW-1:0] rd_addr_i,
  output logic [7:0]              rd_data_o
);
  import smp_pkg::*;

  logic [7:0] mem_q [MaxPayload];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // a read issued in the same cycle as a write to that entry sees the new byte
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/sync_framed_message_parser.sv */
// Top level of the framed message parser: request register, frame state
// machine, result register. Depends on smp_pkg and smp_payload_ram.

// One request enters per clock cycle while in_stall_o is low; its result passes
// through the request register, then the result register. While a result waits,
// the block takes one more request into the request register and then stalls.
// Each request is a received line byte (op 0), a read of a stored payload byte
// (op 1) or a release of the held message (op 2); every request returns one
// result carrying the held message header, status flags and the error count.
// The payload memory read port is registered and is addressed when the request
// is accepted. Memory contents are not cleared at reset; reading an entry that
// no frame has written returns an unspecified byte. Configuration writes are
// always ready and must only be issued while the block is idle.
module sync_framed_message_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  smp_pkg::smp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output smp_pkg::smp_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import smp_pkg::*;

  // configuration
  logic [7:0] sync_first_q, sync_second_q, max_length_q;

  // pipeline control
  logic    req_valid_q, out_valid_q;
  smp_in_t req_q;
  smp_out_t out_q, out_d;
  logic    in_acc, adv;

  // frame state
  phase_e      phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]  class_q, class_d, ident_q, ident_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic        ready_q, ready_d;
  logic [7:0]  err_q, err_d;

  logic        done, fail;
  logic        wr_en;
  logic [7:0]  rd_data, read_data;
  logic [7:0]  c, pos_inc;
  logic [15:0] len_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
      max_length_q  <= MaxLengthRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSyncFirst:  sync_first_q  <= cfg_data_i;
        CfgSyncSecond: sync_second_q <= cfg_data_i;
        CfgMaxLength:  max_length_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the request stage advances whenever the result register is free or draining
  assign adv        = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !(!out_valid_q || !out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        req_valid_q <= 1'b1;
      end else if (adv) begin
        req_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  smp_payload_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (pos_q),
    .wr_data_i (c),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_data_i.read_index),
    .rd_data_o (rd_data)
  );

  assign c        = req_q.rx_byte;
  assign pos_inc  = (pos_q < PosSat) ? pos_q + 8'd1 : pos_q;
  assign len_full = {c, len_q[7:0]};

  always_comb begin
    phase_d   = phase_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    class_d   = class_q;
    ident_d   = ident_q;
    len_d     = len_q;
    pos_d     = pos_q;
    ready_d   = ready_q;
    err_d     = err_q;
    done      = 1'b0;
    fail      = 1'b0;
    wr_en     = 1'b0;
    read_data = 8'd0;

    case (req_q.op)
      OpRxByte: begin
        // checksum covers class through payload
        if (phase_q == PhClass || phase_q == PhIdent || phase_q == PhLenLo ||
            phase_q == PhLenHi || phase_q == PhPayload) begin
          sum_a_d = sum_a_q + c;
          sum_b_d = sum_b_q + sum_a_q + c;
        end
        case (phase_q)
          PhHunt: begin
            if (c == sync_first_q) phase_d = PhSync1;
          end
          PhSync1: begin
            if (c != sync_second_q) begin
              fail = 1'b1;
            end else begin
              sum_a_d = 8'd0;
              sum_b_d = 8'd0;
              phase_d = PhClass;
            end
          end
          PhClass: begin
            // a held message blocks the next frame
            if (ready_q) begin
              fail = 1'b1;
            end else begin
              class_d = c;
              phase_d = PhIdent;
            end
          end
          PhIdent: begin
            ident_d = c;
            phase_d = PhLenLo;
          end
          PhLenLo: begin
            len_d   = {8'd0, c};
            phase_d = PhLenHi;
          end
          PhLenHi: begin
            len_d = len_full;
            if (len_full > {8'd0, max_length_q} || len_full > MaxPayloadLen) begin
              fail = 1'b1;
            end else begin
              pos_d   = 8'd0;
              phase_d = (len_full == 16'd0) ? PhCkA : PhPayload;
            end
          end
          PhPayload: begin
            // write only when the request actually moves on
            wr_en = adv && (pos_q < MaxPayloadIdx);
            pos_d = pos_inc;
            if ({8'd0, pos_inc} >= len_q) phase_d = PhCkA;
          end
          PhCkA: begin
            if (c != sum_a_q) fail = 1'b1;
            else phase_d = PhCkB;
          end
          PhCkB: begin
            if (c != sum_b_q) begin
              fail = 1'b1;
            end else begin
              ready_d = 1'b1;
              done    = 1'b1;
              phase_d = PhHunt;
            end
          end
          default: fail = 1'b1;
        endcase
        if (fail) begin
          err_d   = err_q + 8'd1;
          phase_d = PhHunt;
        end
      end
      OpRead: begin
        if ({8'd0, req_q.read_index} < len_q && req_q.read_index < MaxPayloadIdx) begin
          read_data = rd_data;
        end
      end
      OpRelease: ready_d = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    out_d.frame_ready    = ready_d;
    out_d.frame_done     = done;
    out_d.frame_error    = fail;
    out_d.frame_class    = class_d;
    out_d.msg_ident      = ident_d;
    out_d.payload_length = (len_d[15:8] != 8'd0) ? 8'hFF : len_d[7:0];
    out_d.read_data      = read_data;
    out_d.error_count    = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sum_a_q <= 8'd0;
      sum_b_q <= 8'd0;
      class_q <= 8'd0;
      ident_q <= 8'd0;
      len_q   <= 16'd0;
      pos_q   <= 8'd0;
      ready_q <= 1'b0;
      err_q   <= 8'd0;
    end else if (adv) begin
      phase_q <= phase_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      class_q <= class_d;
      ident_q <= ident_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      ready_q <= ready_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/tb.sv */
// Self-checking testbench for sync_framed_message_parser: drives framed byte
// streams, payload reads and releases, and checks every status word.
// Depends on smp_pkg and the parser RTL only.
module tb;
  import smp_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;

  typedef enum int {
    FrmGood,
    FrmBadSync,
    FrmOversize,
    FrmBadCkA,
    FrmBadCkB,
    FrmTruncated
  } frame_fault_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  smp_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  smp_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // parser image kept by the testbench
  logic [7:0]  cfg_sync_first = SyncFirstRst;
  logic [7:0]  cfg_sync_second = SyncSecondRst;
  logic [7:0]  cfg_max_len = MaxLengthRst;
  phase_e      ph = PhHunt;
  logic [7:0]  ck_a = '0;
  logic [7:0]  ck_b = '0;
  logic [7:0]  hdr_class = '0;
  logic [7:0]  hdr_ident = '0;
  logic [15:0] frame_len = '0;
  logic [7:0]  pay_pos = '0;
  logic [7:0]  payload_copy [MaxPayload];
  bit          payload_written [MaxPayload];
  logic        held = 1'b0;
  logic [7:0]  err_total = '0;

  smp_out_t    status_q[$];
  int unsigned n_sent = 0;
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          stall_now = 1'b0;
  bit          calm = 1'b0;

  sync_framed_message_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned burst_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the parser image by one request and queue the status it returns.
  task automatic parse_request(input smp_in_t req);
    smp_out_t   rsp;
    logic [7:0] c;
    logic       done;
    logic       err;
    logic [7:0] data;
    c    = req.rx_byte;
    done = 1'b0;
    err  = 1'b0;
    data = '0;
    case (req.op)
      OpRxByte: begin
        if (ph inside {PhClass, PhIdent, PhLenLo, PhLenHi, PhPayload}) begin
          ck_a = ck_a + c;
          ck_b = ck_b + ck_a;
        end
        case (ph)
          PhHunt: begin
            if (c == cfg_sync_first) ph = PhSync1;
          end
          PhSync1: begin
            if (c != cfg_sync_second) begin
              err = 1'b1;
            end else begin
              ck_a = '0;
              ck_b = '0;
              ph   = PhClass;
            end
          end
          PhClass: begin
            if (held) begin
              err = 1'b1;
            end else begin
              hdr_class = c;
              ph        = PhIdent;
            end
          end
          PhIdent: begin
            hdr_ident = c;
            ph        = PhLenLo;
          end
          PhLenLo: begin
            frame_len = {8'h00, c};
            ph        = PhLenHi;
          end
          PhLenHi: begin
            frame_len[15:8] = c;
            if (frame_len > {8'h00, cfg_max_len} || frame_len > MaxPayloadLen) begin
              err = 1'b1;
            end else begin
              pay_pos = '0;
              if (frame_len == 16'd0) ph = PhCkA;
              else ph = PhPayload;
            end
          end
          PhPayload: begin
            if (pay_pos < MaxPayloadIdx) begin
              payload_copy[pay_pos]    = c;
              payload_written[pay_pos] = 1'b1;
            end
            if (pay_pos != PosSat) pay_pos = pay_pos + 8'd1;
            if ({8'h00, pay_pos} >= frame_len) ph = PhCkA;
          end
          PhCkA: begin
            if (c != ck_a) err = 1'b1;
            else ph = PhCkB;
          end
          PhCkB: begin
            if (c != ck_b) begin
              err = 1'b1;
            end else begin
              held = 1'b1;
              done = 1'b1;
              ph   = PhHunt;
            end
          end
          default: err = 1'b1;
        endcase
        if (err) begin
          err_total = err_total + 8'd1;
          ph        = PhHunt;
        end
      end
      OpRead: begin
        if ({8'h00, req.read_index} < frame_len && req.read_index < MaxPayloadIdx)
          data = payload_copy[req.read_index];
      end
      OpRelease: held = 1'b0;
      default: ;
    endcase
    rsp.frame_ready    = held;
    rsp.frame_done     = done;
    rsp.frame_error    = err;
    rsp.frame_class    = hdr_class;
    rsp.msg_ident      = hdr_ident;
    rsp.payload_length = (frame_len[15:8] != 8'h00) ? 8'hFF : frame_len[7:0];
    rsp.read_data      = data;
    rsp.error_count    = err_total;
    status_q.push_back(rsp);
  endtask

  // A read must land on a store entry that a frame has written, or at or beyond the frame length.
  function automatic bit read_ok(input logic [7:0] idx);
    return ({8'h00, idx} >= frame_len) || payload_written[idx];
  endfunction

  task automatic send_req(input op_e op, input logic [7:0] rx, input logic [7:0] idx);
    smp_in_t     req;
    int unsigned gap;
    req.op         = op;
    req.rx_byte    = rx;
    req.read_index = idx;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : burst_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    parse_request(req);
    n_sent++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_req(OpRxByte, b, 8'($urandom_range(0, 254)));
  endtask

  task automatic send_release();
    send_req(OpRelease, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 254)));
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] ident,
                            input logic [15:0] len, input frame_fault_e fault);
    logic [7:0]  octets[$];
    logic [7:0]  fa;
    logic [7:0]  fb;
    int unsigned keep;
    int unsigned i;
    octets = {};
    fa     = '0;
    fb     = '0;
    octets.push_back(cfg_sync_first);
    if (fault == FrmBadSync) begin
      octets.push_back(cfg_sync_second ^ 8'($urandom_range(1, 255)));
    end else begin
      octets.push_back(cfg_sync_second);
      octets.push_back(cls);
      octets.push_back(ident);
      octets.push_back(len[7:0]);
      octets.push_back(len[15:8]);
      if (fault != FrmOversize) begin
        for (i = 0; i < len; i++) octets.push_back(8'($urandom_range(0, 255)));
        for (i = 2; i < octets.size(); i++) begin
          fa = fa + octets[i];
          fb = fb + fa;
        end
        if (fault == FrmBadCkA) fa = fa ^ 8'($urandom_range(1, 255));
        if (fault == FrmBadCkB) fb = fb ^ 8'($urandom_range(1, 255));
        octets.push_back(fa);
        octets.push_back(fb);
      end
    end
    keep = octets.size();
    if (fault == FrmTruncated) keep = $urandom_range(1, octets.size() - 1);
    for (i = 0; i < keep; i++) send_rx(octets[i]);
  endtask

  task automatic read_some(input int unsigned count);
    logic [7:0]  idx;
    int unsigned span;
    int unsigned tries;
    repeat (count) begin
      span = (frame_len > 16'd255) ? 255 : frame_len;
      if (span != 0 && $urandom_range(0, 3) != 0) idx = 8'($urandom_range(0, span - 1));
      else idx = 8'($urandom_range(0, 254));
      tries = 0;
      while (!read_ok(idx) && tries < 16) begin
        idx = 8'($urandom_range(0, 254));
        tries++;
      end
      if (read_ok(idx)) send_req(OpRead, 8'($urandom_range(0, 255)), idx);
    end
  endtask

  // Let every outstanding status drain before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_e idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgSyncFirst:  cfg_sync_first = val;
      CfgSyncSecond: cfg_sync_second = val;
      CfgMaxLength:  cfg_max_len = val;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] ml);
    cfg_valid <= 1'b1;
    cfg_put(CfgSyncFirst, sf);
    cfg_put(CfgSyncSecond, ss);
    cfg_put(CfgMaxLength, ml);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return 16'((cfg_max_len < 12) ? $urandom_range(0, cfg_max_len) : $urandom_range(0, 12));
    if (r < 95) return 16'($urandom_range(0, cfg_max_len));
    return {8'h00, cfg_max_len};
  endfunction

  function automatic logic [15:0] pick_oversize();
    if (cfg_max_len < 8'hFF && $urandom_range(0, 1) == 0)
      return 16'($urandom_range(cfg_max_len + 1, 255));
    return {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
  endfunction

  task automatic random_transaction();
    int unsigned  r;
    int unsigned  k;
    frame_fault_e fault;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 24) == 0) calm = !calm;
    if (r < 55) begin
      k = $urandom_range(0, 99);
      if (k < 70) fault = FrmGood;
      else if (k < 77) fault = FrmBadCkA;
      else if (k < 84) fault = FrmBadCkB;
      else if (k < 90) fault = FrmBadSync;
      else if (k < 96) fault = FrmOversize;
      else fault = FrmTruncated;
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 (fault == FrmOversize) ? pick_oversize() : pick_len(), fault);
      if (held) begin
        read_some($urandom_range(0, 4));
        if ($urandom_range(0, 9) != 0) send_release();
      end
    end else if (r < 68) begin
      read_some($urandom_range(1, 3));
    end else if (r < 78) begin
      send_release();
    end else if (r < 92) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0) send_rx(cfg_sync_first);
        else send_rx(8'($urandom_range(0, 255)));
      end
    end else begin
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_len(),
                 FrmTruncated);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_idle_requests();
    send_release();
    send_req(OpRead, 8'h00, 8'd0);
    send_req(OpRead, 8'hFF, 8'd254);
  endtask

  task automatic test_bad_second_sync();
    send_frame(8'h00, 8'h00, 16'd0, FrmBadSync);
  endtask

  task automatic test_oversize_length();
    send_frame(8'h01, 8'h02, 16'h0100, FrmOversize);
  endtask

  task automatic test_zero_length_frame();
    send_frame(8'hFF, 8'h00, 16'd0, FrmGood);
  endtask

  task automatic test_reject_while_ready();
    send_rx(cfg_sync_first);
    send_rx(cfg_sync_second);
    send_rx(8'hA5);
    send_release();
  endtask

  task automatic test_checksum_mismatch();
    send_frame(8'h00, 8'hFF, 16'd0, FrmBadCkA);
  endtask

  task automatic test_random_stream(input logic [7:0] sf, input logic [7:0] ss,
                                    input logic [7:0] ml, input int unsigned count);
    int unsigned start;
    drain();
    write_config(sf, ss, ml);
    calm  = 1'b0;
    start = n_sent;
    while (n_sent - start < count) random_transaction();
  endtask

  // ---------------------------------------------------------------- status checks

  task automatic report(input string field, input logic [7:0] exp_v, input logic [7:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    smp_out_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected status %0h, expected none", $time, out_data);
        fail_cnt++;
      end else begin
        exp_s = status_q.pop_front();
        if (out_data.frame_ready !== exp_s.frame_ready)
          report("frame_ready", 8'(exp_s.frame_ready), 8'(out_data.frame_ready));
        if (out_data.frame_done !== exp_s.frame_done)
          report("frame_done", 8'(exp_s.frame_done), 8'(out_data.frame_done));
        if (out_data.frame_error !== exp_s.frame_error)
          report("frame_error", 8'(exp_s.frame_error), 8'(out_data.frame_error));
        if (out_data.frame_class !== exp_s.frame_class)
          report("frame_class", exp_s.frame_class, out_data.frame_class);
        if (out_data.msg_ident !== exp_s.msg_ident)
          report("msg_ident", exp_s.msg_ident, out_data.msg_ident);
        if (out_data.payload_length !== exp_s.payload_length)
          report("payload_length", exp_s.payload_length, out_data.payload_length);
        if (out_data.read_data !== exp_s.read_data)
          report("read_data", exp_s.read_data, out_data.read_data);
        if (out_data.error_count !== exp_s.error_count)
          report("error_count", exp_s.error_count, out_data.error_count);
      end
    end
  end

  // Output backpressure: mostly short stalls, a few long ones, no new ones while calm.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_now  = !calm && ($urandom_range(0, 3) == 0);
      stall_left = stall_now ? burst_len() : $urandom_range(1, 8);
    end
    stall_left--;
    out_stall <= stall_now;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no request or status moved for %0d cycles", $time, idle_cycles);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_requests();
    test_bad_second_sync();
    test_oversize_length();
    test_zero_length_frame();
    test_reject_while_ready();
    test_checksum_mismatch();
    test_random_stream(SyncFirstRst, SyncSecondRst, MaxLengthRst, 200);
    test_random_stream(8'h00, 8'hFF, 8'd0, 120);
    test_random_stream(8'hFF, 8'h00, 8'd8, 200);
    test_random_stream(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 200);
    test_random_stream(SyncFirstRst, SyncSecondRst, 8'd255, 200);
    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/smp_pkg.sv
rtl/smp_payload_ram.sv
rtl/sync_framed_message_parser.sv
dv/tb.sv
